/* hdl/krb_pkg.sv */
// shared types, codes and reset values for the key repeat and beeper block
package krb_pkg;

    // default number of key lines
    localparam int KEY_LINES_DEF = 8;

    // field and register widths
    localparam int OP_W    = 2;
    localparam int REQ_W   = 2;
    localparam int COUNT_W = 5;
    localparam int TICK_W  = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 3;

    // item operation codes
    localparam logic [OP_W-1:0] OP_KEY_SCAN  = 2'd0;
    localparam logic [OP_W-1:0] OP_BELL_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_BELL_CMD  = 2'd2;

    // bell command codes
    localparam logic [REQ_W-1:0] REQ_STOP     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SINGLE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PERIODIC = 2'd2;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_ACCEPT       = 3'd0;
    localparam logic [INDEX_W-1:0] REG_REPEAT_FIRST = 3'd1;
    localparam logic [INDEX_W-1:0] REG_REPEAT_AGAIN = 3'd2;
    localparam logic [INDEX_W-1:0] REG_BEEP_ON      = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BEEP_OFF     = 3'd4;

    // register reset values
    localparam logic [COUNT_W-1:0] ACCEPT_RST       = 5'd3;
    localparam logic [COUNT_W-1:0] REPEAT_FIRST_RST = 5'd13;
    localparam logic [COUNT_W-1:0] REPEAT_AGAIN_RST = 5'd20;
    localparam logic [TICK_W-1:0]  BEEP_ON_RST      = 8'd5;
    localparam logic [TICK_W-1:0]  BEEP_OFF_RST     = 8'd10;

    // hold count saturates here
    localparam logic [COUNT_W-1:0] HOLD_MAX = 5'd31;

    // beeper modes
    typedef enum logic [1:0] {
        BELL_STOPPED   = 2'd0,
        BELL_SINGLE    = 2'd1,
        BELL_ON_PHASE  = 2'd2,
        BELL_OFF_PHASE = 2'd3
    } bell_mode_t;

endpackage

/* hdl/key_repeat_and_beeper.sv */
// Keypad qualifier with auto-repeat and beeper timer, top level.
// Each beat on the s_ channel is one key scan tick, bell tick or bell command;
// it produces exactly one result beat on the m_ channel with the reported key
// pattern (zero unless this scan reaches the accept or a repeat count) and the
// beeper level after the item. An item passes an input register, then one
// pass of short logic updates the key and beeper state and loads the result
// register, so one item is taken every cycle; throughput drops only while
// the result register is held by m_ready low. The user must set counts and
// beep timing through the APB port only while no item is in flight; the
// block itself does not enforce this.
module key_repeat_and_beeper #(
    parameter int KEY_LINES = krb_pkg::KEY_LINES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [krb_pkg::ADDR_W-1:0]      paddr,
    input  logic [krb_pkg::DATA_W-1:0]      pwdata,
    output logic [krb_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [krb_pkg::OP_W-1:0]        s_op,
    input  logic [KEY_LINES-1:0]            s_key_lines,
    input  logic [krb_pkg::REQ_W-1:0]       s_bell_request,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [KEY_LINES-1:0]            m_key_code,
    output logic                            m_bell_drive
);
    import krb_pkg::*;

    // configuration registers
    logic [COUNT_W-1:0] accept_count_reg;
    logic [COUNT_W-1:0] repeat_first_count_reg;
    logic [COUNT_W-1:0] repeat_again_count_reg;
    logic [TICK_W-1:0]  beep_on_ticks_reg;
    logic [TICK_W-1:0]  beep_off_ticks_reg;
    logic               cfg_write;
    logic [INDEX_W-1:0] cfg_index;

    // input stage
    logic                 in_vld_reg;
    logic [OP_W-1:0]      op_reg;
    logic [KEY_LINES-1:0] key_lines_reg;
    logic [REQ_W-1:0]     bell_request_reg;

    // state
    logic [KEY_LINES-1:0] last_pattern_reg, last_pattern_next;
    logic [COUNT_W-1:0]   hold_count_reg, hold_count_next;
    bell_mode_t           bell_mode_reg, bell_mode_next;
    logic [TICK_W-1:0]    bell_remaining_reg, bell_remaining_next;

    // result stage
    logic                 out_vld_reg;
    logic [KEY_LINES-1:0] key_code_reg, key_code_next;
    logic                 bell_drive_reg, bell_drive_next;

    // handshake and pipeline advance
    logic                 fire;
    logic                 s_fire;

    // key scan intermediates
    logic [KEY_LINES-1:0] pressed;
    logic [COUNT_W-1:0]   hold_inc;
    logic                 hit;
    logic                 key_beep;
    logic [TICK_W-1:0]    remaining_dec;

    // apb decode
    assign pready    = 1'b1;
    assign cfg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_ACCEPT:       prdata = {{(DATA_W-COUNT_W){1'b0}}, accept_count_reg};
            REG_REPEAT_FIRST: prdata = {{(DATA_W-COUNT_W){1'b0}}, repeat_first_count_reg};
            REG_REPEAT_AGAIN: prdata = {{(DATA_W-COUNT_W){1'b0}}, repeat_again_count_reg};
            REG_BEEP_ON:      prdata = {{(DATA_W-TICK_W){1'b0}}, beep_on_ticks_reg};
            REG_BEEP_OFF:     prdata = {{(DATA_W-TICK_W){1'b0}}, beep_off_ticks_reg};
            default:          prdata = '0;
        endcase
    end

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_count_reg       <= ACCEPT_RST;
            repeat_first_count_reg <= REPEAT_FIRST_RST;
            repeat_again_count_reg <= REPEAT_AGAIN_RST;
            beep_on_ticks_reg      <= BEEP_ON_RST;
            beep_off_ticks_reg     <= BEEP_OFF_RST;
        end else if (cfg_write && pready) begin
            unique case (cfg_index)
                REG_ACCEPT:       accept_count_reg       <= pwdata[COUNT_W-1:0];
                REG_REPEAT_FIRST: repeat_first_count_reg <= pwdata[COUNT_W-1:0];
                REG_REPEAT_AGAIN: repeat_again_count_reg <= pwdata[COUNT_W-1:0];
                REG_BEEP_ON:      beep_on_ticks_reg      <= pwdata[TICK_W-1:0];
                REG_BEEP_OFF:     beep_off_ticks_reg     <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // the work stage runs when an item waits and the result register can load
    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;
    assign s_fire  = s_valid && s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg           <= s_op;
            key_lines_reg    <= s_key_lines;
            bell_request_reg <= s_bell_request;
        end
    end

    // key qualifier terms
    assign pressed       = ~key_lines_reg;
    assign hold_inc      = hold_count_reg + COUNT_W'(1);
    assign hit           = (hold_inc == accept_count_reg) ||
                           (hold_inc == repeat_first_count_reg) ||
                           (hold_inc == repeat_again_count_reg);
    assign remaining_dec = bell_remaining_reg - TICK_W'(1);

    // key state and report
    always_comb begin
        last_pattern_next = last_pattern_reg;
        hold_count_next   = hold_count_reg;
        key_code_next     = '0;
        key_beep          = 1'b0;
        if (op_reg == OP_KEY_SCAN && pressed != '0) begin
            if (pressed != last_pattern_reg) begin
                last_pattern_next = pressed;
                hold_count_next   = '0;
            end else if (hold_count_reg != HOLD_MAX) begin
                hold_count_next = hold_inc;
                if (hit) begin
                    key_code_next = pressed;
                    key_beep      = 1'b1;
                    // later repeats fold back to the first repeat count
                    if (hold_inc == repeat_again_count_reg) begin
                        hold_count_next = repeat_first_count_reg;
                    end
                end
            end
        end
    end

    // beeper next state
    always_comb begin
        bell_mode_next      = bell_mode_reg;
        bell_remaining_next = bell_remaining_reg;
        if (key_beep) begin
            bell_mode_next      = BELL_SINGLE;
            bell_remaining_next = beep_on_ticks_reg;
        end else if (op_reg == OP_BELL_CMD) begin
            priority if (bell_request_reg == REQ_SINGLE) begin
                bell_mode_next      = BELL_SINGLE;
                bell_remaining_next = beep_on_ticks_reg;
            end else if (bell_request_reg == REQ_PERIODIC) begin
                bell_mode_next      = BELL_ON_PHASE;
                bell_remaining_next = beep_on_ticks_reg;
            end else begin
                bell_mode_next = BELL_STOPPED;
            end
        end else if (op_reg == OP_BELL_TICK && bell_mode_reg != BELL_STOPPED) begin
            bell_remaining_next = remaining_dec;
            if (remaining_dec == '0) begin
                unique case (bell_mode_reg)
                    BELL_SINGLE: begin
                        bell_mode_next = BELL_STOPPED;
                    end
                    BELL_ON_PHASE: begin
                        bell_mode_next      = BELL_OFF_PHASE;
                        bell_remaining_next = beep_off_ticks_reg;
                    end
                    BELL_OFF_PHASE: begin
                        bell_mode_next      = BELL_ON_PHASE;
                        bell_remaining_next = beep_on_ticks_reg;
                    end
                    default: begin
                        bell_mode_next = BELL_STOPPED;
                    end
                endcase
            end
        end
    end

    // beeper output level follows the mode
    always_comb begin
        unique case (bell_mode_next)
            BELL_SINGLE, BELL_ON_PHASE: bell_drive_next = 1'b1;
            default:                    bell_drive_next = 1'b0;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pattern_reg   <= '0;
            hold_count_reg     <= '0;
            bell_mode_reg      <= BELL_STOPPED;
            bell_remaining_reg <= '0;
        end else if (fire) begin
            last_pattern_reg   <= last_pattern_next;
            hold_count_reg     <= hold_count_next;
            bell_mode_reg      <= bell_mode_next;
            bell_remaining_reg <= bell_remaining_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            key_code_reg   <= key_code_next;
            bell_drive_reg <= bell_drive_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_key_code   = key_code_reg;
    assign m_bell_drive = bell_drive_reg;

`ifndef ASSERT_OFF
    // a reported key always starts a beep
    a_key_beeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && key_code_reg != '0) |-> bell_drive_reg)
        else $error("key report without beeper on");

    // a stopped beeper is never shown driving
    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && bell_mode_next == BELL_STOPPED) |=> !bell_drive_reg)
        else $error("beeper driven while stopped");

    // key state moves only when an item is worked on
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(hold_count_reg) && $stable(last_pattern_reg)))
        else $error("key state changed without an item");
`endif

endmodule

/* tb/keypad_bell_checker.sv */
// checker for the keypad qualifier and beeper: predicts each result beat and compares it
`timescale 1ns / 100ps

module keypad_bell_checker #(
    parameter int KEY_W = krb_pkg::KEY_LINES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port, watched for register writes
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [krb_pkg::ADDR_W-1:0]  paddr,
    input  logic [krb_pkg::DATA_W-1:0]  pwdata,
    // input channel
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [krb_pkg::OP_W-1:0]    s_op,
    input  logic [KEY_W-1:0]            s_key_lines,
    input  logic [krb_pkg::REQ_W-1:0]   s_bell_request,
    // result channel
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [KEY_W-1:0]            m_key_code,
    input  logic                        m_bell_drive,
    // status for the top
    output int                          results_owed,
    output int                          mismatch_count
);
    import krb_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             bell_drive;
    } keypad_result_t;

    // results predicted but not yet seen on the m_ channel
    keypad_result_t owed_results[$];

    // register copies
    logic [COUNT_W-1:0] accept_cnt;
    logic [COUNT_W-1:0] first_cnt;
    logic [COUNT_W-1:0] again_cnt;
    logic [TICK_W-1:0]  on_ticks;
    logic [TICK_W-1:0]  off_ticks;

    // key and beeper state
    logic [KEY_W-1:0]   held_pattern;
    logic [COUNT_W-1:0] hold_cnt;
    bell_mode_t         bell_mode;
    logic [TICK_W-1:0]  bell_left;
    logic               bell_on;

    // bell command: single and periodic start an on phase, anything else stops
    function automatic void apply_bell_request(input logic [REQ_W-1:0] req);
        if (req == REQ_SINGLE || req == REQ_PERIODIC) begin
            bell_mode = (req == REQ_SINGLE) ? BELL_SINGLE : BELL_ON_PHASE;
            bell_left = on_ticks;
            bell_on   = 1'b1;
        end else begin
            // remaining ticks are kept on stop
            bell_mode = BELL_STOPPED;
            bell_on   = 1'b0;
        end
    endfunction

    // bell tick: count down, switch phase when the timer hits zero
    function automatic void advance_bell();
        if (bell_mode == BELL_STOPPED)
            return;
        bell_left = bell_left - 1'b1;
        if (bell_left != '0)
            return;
        case (bell_mode)
            BELL_SINGLE: begin
                bell_on   = 1'b0;
                bell_mode = BELL_STOPPED;
            end
            BELL_ON_PHASE: begin
                bell_left = off_ticks;
                bell_on   = 1'b0;
                bell_mode = BELL_OFF_PHASE;
            end
            default: begin
                bell_left = on_ticks;
                bell_on   = 1'b1;
                bell_mode = BELL_ON_PHASE;
            end
        endcase
    endfunction

    // key scan: qualify a steady pattern, report at accept and repeat counts
    function automatic logic [KEY_W-1:0] scan_keys(input logic [KEY_W-1:0] lines);
        logic [KEY_W-1:0] pressed;
        pressed = ~lines;
        if (pressed == '0)
            return '0;
        if (pressed != held_pattern) begin
            held_pattern = pressed;
            hold_cnt     = '0;
            return '0;
        end
        if (hold_cnt == HOLD_MAX)
            return '0;
        hold_cnt = hold_cnt + 1'b1;
        if (hold_cnt == accept_cnt || hold_cnt == first_cnt || hold_cnt == again_cnt) begin
            apply_bell_request(REQ_SINGLE);
            if (hold_cnt == again_cnt)
                hold_cnt = first_cnt;
            return pressed;
        end
        return '0;
    endfunction

    function automatic keypad_result_t predict_item(input logic [OP_W-1:0] op,
                                                    input logic [KEY_W-1:0] lines,
                                                    input logic [REQ_W-1:0] req);
        keypad_result_t res;
        res.key_code = '0;
        case (op)
            OP_KEY_SCAN:  res.key_code = scan_keys(lines);
            OP_BELL_TICK: advance_bell();
            OP_BELL_CMD:  apply_bell_request(req);
            default: ;
        endcase
        res.bell_drive = bell_on;
        return res;
    endfunction

    function automatic void load_register(input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data);
        case (INDEX_W'(addr >> 2))
            REG_ACCEPT:       accept_cnt = data[COUNT_W-1:0];
            REG_REPEAT_FIRST: first_cnt  = data[COUNT_W-1:0];
            REG_REPEAT_AGAIN: again_cnt  = data[COUNT_W-1:0];
            REG_BEEP_ON:      on_ticks   = data[TICK_W-1:0];
            REG_BEEP_OFF:     off_ticks  = data[TICK_W-1:0];
            default: ;
        endcase
    endfunction

    // watch both channels; results are taken before new items at the same edge
    always @(posedge aclk) begin
        keypad_result_t want;
        if (!aresetn) begin
            accept_cnt   = ACCEPT_RST;
            first_cnt    = REPEAT_FIRST_RST;
            again_cnt    = REPEAT_AGAIN_RST;
            on_ticks     = BEEP_ON_RST;
            off_ticks    = BEEP_OFF_RST;
            held_pattern = '0;
            hold_cnt     = '0;
            bell_mode    = BELL_STOPPED;
            bell_left    = '0;
            bell_on      = 1'b0;
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result beat: key_code %0h bell_drive %0b",
                           m_key_code, m_bell_drive);
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_key_code !== want.key_code) begin
                        $error("key_code: expected %0h, got %0h", want.key_code, m_key_code);
                        mismatch_count++;
                    end
                    if (m_bell_drive !== want.bell_drive) begin
                        $error("bell_drive: expected %0b, got %0b",
                               want.bell_drive, m_bell_drive);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                owed_results.push_back(predict_item(s_op, s_key_lines, s_bell_request));
            if (psel && penable && pwrite && pready)
                load_register(paddr, pwdata);
        end
        results_owed = owed_results.size();
    end

endmodule

/* tb/tb_top.sv */
// top of the keypad qualifier and beeper testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import krb_pkg::*;

    localparam int KEY_W       = KEY_LINES_DEF;
    localparam int SETTLE      = 4;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 60;

    // codes outside the defined sets
    localparam logic [OP_W-1:0]  OP_SPARE  = 2'd3;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [ADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [OP_W-1:0]    s_op           = OP_KEY_SCAN;
    logic [KEY_W-1:0]   s_key_lines    = '1;
    logic [REQ_W-1:0]   s_bell_request = REQ_STOP;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [KEY_W-1:0]   m_key_code;
    logic               m_bell_drive;

    int results_owed;
    int mismatch_count;
    int hold_asks   = 0;
    int idle_cycles = 0;
    bit sender_calm = 1'b0;

    key_repeat_and_beeper dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key_lines    (s_key_lines),
        .s_bell_request (s_bell_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_code     (m_key_code),
        .m_bell_drive   (m_bell_drive)
    );

    keypad_bell_checker #(.KEY_W(KEY_W)) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key_lines    (s_key_lines),
        .s_bell_request (s_bell_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_code     (m_key_code),
        .m_bell_drive   (m_bell_drive),
        .results_owed   (results_owed),
        .mismatch_count (mismatch_count)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure, with requested long hold-offs and calm stretches
    initial begin : result_sink
        int holds_done;
        int calm_left;
        int gap;
        holds_done = 0;
        calm_left  = 0;
        @(posedge aclk);
        forever begin
            if (holds_done != hold_asks) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if (calm_left > 0) begin
                m_ready <= 1'b1;
                calm_left--;
                @(posedge aclk);
            end else if ($urandom_range(0, 19) == 0) begin
                calm_left = $urandom_range(30, 150);
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                gap = pick_gap(1'b0);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // one input beat; entered and left at a rising edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] lines,
                             input logic [REQ_W-1:0] req);
        int gap;
        bit took;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_key_lines    <= lines;
        s_bell_request <= req;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_owed != 0);
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [INDEX_W-1:0] idx, input int value);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            done = pready;
            @(posedge aclk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // new counts and beep timing, only once the block has gone quiet
    task automatic set_phase(input int acc, input int first, input int again,
                             input int on_t, input int off_t);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        write_register(REG_ACCEPT, acc);
        write_register(REG_REPEAT_FIRST, first);
        write_register(REG_REPEAT_AGAIN, again);
        write_register(REG_BEEP_ON, on_t);
        write_register(REG_BEEP_OFF, off_t);
    endtask

    // random traffic: mostly held key patterns, plus ticks, commands and noise
    task automatic run_items(input int quota);
        int sent;
        int kind;
        int len;
        int i;
        logic [KEY_W-1:0] held;
        sent = 0;
        while (sent < quota) begin
            kind        = $urandom_range(0, 99);
            sender_calm = ($urandom_range(0, 4) == 0);
            if (kind < 55) begin
                if ($urandom_range(0, 1) == 1)
                    held = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                else
                    held = KEY_W'($urandom_range(1, 255));
                len = $urandom_range(2, 45);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) < 2)
                        send_item(OP_BELL_TICK, KEY_W'($urandom), REQ_W'($urandom));
                    else if ($urandom_range(0, 29) == 0)
                        send_item(OP_KEY_SCAN, '1, REQ_W'($urandom));
                    else
                        send_item(OP_KEY_SCAN, ~held, REQ_W'($urandom));
                end
                sent += len;
            end else if (kind < 80) begin
                len = $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                    send_item(OP_BELL_TICK, KEY_W'($urandom), REQ_W'($urandom));
                sent += len;
            end else if (kind < 92) begin
                send_item(OP_BELL_CMD, KEY_W'($urandom), REQ_W'($urandom));
                sent++;
            end else begin
                send_item(OP_W'($urandom), KEY_W'($urandom), REQ_W'($urandom));
                sent++;
            end
        end
        sender_calm = 1'b0;
    endtask

    initial begin : stimulus
        int i;
        int p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with the reset settings
        send_item(OP_SPARE, 8'h5a, REQ_PERIODIC);         // unused op
        send_item(OP_KEY_SCAN, '1, REQ_STOP);             // all released
        for (i = 0; i < 5; i++)
            send_item(OP_KEY_SCAN, '0, REQ_STOP);         // every key held, reported
        send_item(OP_KEY_SCAN, 8'hfe, REQ_STOP);          // new pattern restarts count
        send_item(OP_BELL_CMD, '0, REQ_PERIODIC);
        for (i = 0; i < 6; i++)
            send_item(OP_BELL_TICK, '1, REQ_STOP);
        send_item(OP_BELL_CMD, '0, REQ_SPARE);            // odd request acts as stop
        send_item(OP_BELL_TICK, '0, REQ_SINGLE);          // tick while stopped
        send_item(OP_BELL_CMD, '1, REQ_SINGLE);
        send_item(OP_BELL_TICK, 8'ha5, REQ_STOP);
        send_item(OP_BELL_TICK, 8'h5a, REQ_STOP);
        send_item(OP_BELL_CMD, '1, REQ_STOP);

        // reset settings, with a long result hold-off and a full drain midway
        run_items(PHASE_ITEMS / 2);
        hold_asks <= hold_asks + 1;
        run_items(PHASE_ITEMS / 2);
        wait_drained();
        run_items(PHASE_ITEMS / 2);

        // low extremes: the hold count climbs to its ceiling and sticks
        set_phase(1, 2, 1, 1, 1);
        run_items(PHASE_ITEMS);

        // high extremes
        set_phase(31, 31, 31, 255, 255);
        run_items(PHASE_ITEMS);

        // zero tick counts: timer wraps, so one phase lasts 256 ticks
        set_phase(2, 5, 8, 0, 0);
        send_item(OP_BELL_CMD, '1, REQ_PERIODIC);
        sender_calm = 1'b1;
        for (i = 0; i < 260; i++)
            send_item(OP_BELL_TICK, KEY_W'($urandom), REQ_W'($urandom));
        sender_calm = 1'b0;
        run_items(PHASE_ITEMS / 2);

        // random settings
        for (p = 0; p < 3; p++) begin
            set_phase($urandom_range(1, 31), $urandom_range(1, 31), $urandom_range(1, 31),
                      $urandom_range(1, 20), $urandom_range(1, 20));
            run_items(PHASE_ITEMS);
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
